### rtl/core/case_folding_string_hash_assert.svh
// Assertion macros shared by the hash block's checker.
`ifndef CASE_FOLDING_STRING_HASH_ASSERT_SVH
`define CASE_FOLDING_STRING_HASH_ASSERT_SVH

// Property that must hold at the current clock edge.
`define CFSH_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent now, consequent in the next cycle.
`define CFSH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

### rtl/core/cfsh_pkg.sv
// Package: constants, phase type and byte helpers for the string hash.
package cfsh_pkg;

	localparam logic [31:0] HashMult = 32'hB3CB_2E29;
	localparam logic [31:0] HashSeed = 32'h3197_12C3;
	localparam logic [31:0] AllOnes  = 32'hFFFF_FFFF;
	localparam logic [31:0] HexLimit = 32'h0FFF_FFFF;

	localparam logic [7:0] CharNul   = 8'h00;
	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharNine  = 8'h39;
	localparam logic [7:0] CharX     = 8'h78;
	localparam logic [7:0] CharUpA   = 8'h41;
	localparam logic [7:0] CharUpF   = 8'h46;
	localparam logic [7:0] CharUpZ   = 8'h5A;
	localparam logic [7:0] CharLoA   = 8'h61;
	localparam logic [7:0] CharLoF   = 8'h66;

	typedef enum logic [1:0] {
		PH_START,
		PH_AFTER_ZERO,
		PH_HASH,
		PH_HEX
	} phase_t;

	// Hex digit lookup result.
	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_digit_t;

	// A-Z to lower case; top-bit bytes sign-extended.
	function automatic logic [31:0] fold_byte(input logic [7:0] b);
		logic [31:0] r;
		if (b >= CharUpA && b <= CharUpZ) begin
			r = {24'h0, b | 8'h20};
		end else if (b[7]) begin
			r = {24'hFF_FFFF, b};
		end else begin
			r = {24'h0, b};
		end
		return r;
	endfunction

	function automatic hex_digit_t hex_digit(input logic [7:0] b);
		hex_digit_t r;
		r.valid = 1'b1;
		r.value = b[3:0];
		if (b >= CharZero && b <= CharNine) begin
			r.value = b[3:0];
		end else if ((b >= CharLoA && b <= CharLoF) || (b >= CharUpA && b <= CharUpF)) begin
			// 'a'/'A' have low nibble 1, so add nine
			r.value = b[3:0] + 4'd9;
		end else begin
			r.valid = 1'b0;
		end
		return r;
	endfunction

endpackage

### rtl/core/case_folding_string_hash.sv
// Top level: case-folding 32-bit string hash with a hex-literal bypass.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata[7:0] char_in
//  m_*     | out | m_tvalid/m_tready  | m_tdata[31:0] hash_value, m_tuser was_hex
//
// One byte per cycle while the input is not stalled. Each byte is held in the
// input register; the fold, XOR and 32x32 multiply (low half) run between it
// and the accumulator, and a terminator item is passed from the input register
// to the result register.
// Reset clears the phase, accumulator, flags and both valid bits.
// Input stalls only when a terminator is waiting and the result register
// is still held by the sink; other bytes move on regardless.
module case_folding_string_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] hash_value
	output logic        m_tuser    // [0] was_hex
);
	import cfsh_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// hash state
	phase_t      phase_q;
	logic [31:0] acc_q;
	logic        hex_ovf_q;
	logic        hex_stop_q;

	// result register
	logic        out_valid_q;
	logic [31:0] out_hash_q;
	logic        out_hex_q;

	// next-state logic
	phase_t      phase_d;
	logic [31:0] acc_d;
	logic        hex_ovf_d;
	logic        hex_stop_d;
	logic        emit;
	logic [31:0] emit_hash;
	logic        emit_hex;

	logic [31:0] mix_in;
	logic [31:0] mix_res;
	hex_digit_t  digit;
	logic        is_nul;
	logic        consume;

	assign is_nul  = (byte_s1 == CharNul);
	// A terminator needs the result register free (or freeing this cycle).
	assign consume  = valid_s1 && (!is_nul || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || consume;

	assign mix_in  = ((phase_q == PH_START) ? HashSeed : acc_q) ^ fold_byte(byte_s1);
	assign mix_res = mix_in * HashMult;
	assign digit   = hex_digit(byte_s1);

	always_comb begin
		phase_d    = phase_q;
		acc_d      = acc_q;
		hex_ovf_d  = hex_ovf_q;
		hex_stop_d = hex_stop_q;
		emit       = 1'b0;
		emit_hash  = mix_res;
		emit_hex   = 1'b0;
		case (phase_q)
			PH_HEX: begin
				if (is_nul) begin
					emit      = 1'b1;
					emit_hex  = 1'b1;
					emit_hash = hex_ovf_q ? AllOnes : acc_q;
				end else if (!hex_stop_q && !hex_ovf_q) begin
					if (!digit.valid) begin
						hex_stop_d = 1'b1;
					end else if (acc_q > HexLimit) begin
						hex_ovf_d = 1'b1;
						acc_d     = AllOnes;
					end else begin
						acc_d = {acc_q[27:0], digit.value};
					end
				end
			end
			PH_AFTER_ZERO: begin
				if (byte_s1 == CharX) begin
					phase_d    = PH_HEX;
					acc_d      = '0;
					hex_ovf_d  = 1'b0;
					hex_stop_d = 1'b0;
				end else begin
					acc_d   = mix_res;
					emit    = is_nul;
					phase_d = PH_HASH;
				end
			end
			PH_START: begin
				acc_d   = mix_res;
				emit    = is_nul;
				phase_d = (byte_s1 == CharZero) ? PH_AFTER_ZERO : PH_HASH;
			end
			default: begin
				acc_d   = mix_res;
				emit    = is_nul;
				phase_d = PH_HASH;
			end
		endcase
		// terminator returns to the start of a new name
		if (is_nul) begin
			phase_d    = PH_START;
			acc_d      = '0;
			hex_ovf_d  = 1'b0;
			hex_stop_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			acc_q      <= '0;
			hex_ovf_q  <= 1'b0;
			hex_stop_q <= 1'b0;
		end else if (consume) begin
			phase_q    <= phase_d;
			acc_q      <= acc_d;
			hex_ovf_q  <= hex_ovf_d;
			hex_stop_q <= hex_stop_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && emit) begin
			out_hash_q <= emit_hash;
			out_hex_q  <= emit_hex;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_hash_q;
	assign m_tuser  = out_hex_q;

endmodule

### rtl/core/cfsh_checker.sv
// Port-level checker for the string hash, bound to the top level.
module cfsh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);
`include "case_folding_string_hash_assert.svh"

	// held result keeps its payload
	`CFSH_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser),
		"result dropped or changed while stalled")

	// input back-pressure only comes from a blocked result
	`CFSH_ASSERT(a_stall_cause, !s_tready |-> m_tvalid && !m_tready, "input stalled with result side free")

	// a ready sink frees the waiting terminator, so input is open
	`CFSH_ASSERT(a_stall_release, m_tready |-> s_tready, "input held off while the sink is ready")

	// a stall persists while the sink keeps holding off
	`CFSH_ASSERT(a_stall_persist, (!s_tready && !m_tready) ##1 !m_tready |-> !s_tready, "stall released early")

endmodule

bind case_folding_string_hash cfsh_checker u_cfsh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### verif/case_folding_string_hash_tb.sv
// Testbench for the case-folding string hash: directed table, random names, scoreboard.
module case_folding_string_hash_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cfsh_pkg::*;

	localparam int HOLD_CYCLES   = 300;     // long sink hold-off while names keep coming
	localparam int RANDOM_ITEMS  = 600;     // random bytes to offer
	localparam int CYCLE_LIMIT   = 200_000; // far beyond the slowest correct run
	localparam int REPORT_LIMIT  = 40;      // mismatch lines printed, all counted
	localparam int DIRECTED_ROWS = 7;

	// one byte of a name on its way to the block; typed rows carry their answer
	typedef struct packed {
		logic [7:0]  ch;
		logic        typed;
		logic [31:0] hash;
		logic        hex;
	} char_item_t;

	// hash or hex value awaited from the block
	typedef struct packed {
		logic [31:0] hash;
		logic        hex;
	} name_result_t;

	// directed name: bytes first-lowest, terminator included in len
	typedef struct packed {
		logic [47:0] text;
		logic [3:0]  len;
		logic        typed;
		logic [31:0] hash;
		logic        hex;
	} name_row_t;

	typedef enum {
		KIND_HEX,
		KIND_PLAIN,
		KIND_ZERO_LEAD,
		KIND_BAD_PREFIX,
		KIND_LONG_HEX
	} name_kind_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] char_in
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] hash_value
	logic        m_tuser;   // [0] was_hex

	case_folding_string_hash dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state: where we are in the current name
	phase_t      name_phase;
	logic [31:0] name_acc;
	logic        hex_sat;
	logic        hex_done;

	char_item_t   name_bytes [$];   // bytes still to offer
	name_result_t awaited_q [$];    // results owed by the block, oldest first
	name_row_t    directed_rows [DIRECTED_ROWS];

	int mismatch_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	bit hold_req = 1'b0;

	function automatic void restart_name();
		name_phase = PH_START;
		name_acc   = '0;
		hex_sat    = 1'b0;
		hex_done   = 1'b0;
	endfunction

	// Advance the name state by one byte; returns 1 when a result falls out.
	function automatic bit hash_byte(input logic [7:0] ch, output logic [31:0] hash,
			output logic hex);
		logic [31:0] folded;
		logic [31:0] mix_in;
		logic [7:0]  digit;
		bit          digit_ok;
		hash = '0;
		hex  = 1'b0;
		// A-Z folded down, top-bit bytes sign-extended
		if (ch >= CharUpA && ch <= CharUpZ) begin
			folded = {24'h0, ch + 8'd32};
		end else begin
			folded = {{24{ch[7]}}, ch};
		end

		if (name_phase == PH_HEX) begin
			if (ch == CharNul) begin
				hash = hex_sat ? AllOnes : name_acc;
				hex  = 1'b1;
				restart_name();
				return 1'b1;
			end
			// once stopped or saturated, bytes are ignored up to the terminator
			if (!hex_done && !hex_sat) begin
				digit_ok = 1'b1;
				digit    = '0;
				if (ch >= CharZero && ch <= CharNine) begin
					digit = ch - CharZero;
				end else if (ch >= CharLoA && ch <= CharLoF) begin
					digit = ch - CharLoA + 8'd10;
				end else if (ch >= CharUpA && ch <= CharUpF) begin
					digit = ch - CharUpA + 8'd10;
				end else begin
					digit_ok = 1'b0;
				end
				if (!digit_ok) begin
					hex_done = 1'b1;
				end else if (name_acc > HexLimit) begin
					hex_sat  = 1'b1;
					name_acc = AllOnes;
				end else begin
					name_acc = {name_acc[27:0], digit[3:0]};
				end
			end
			return 1'b0;
		end

		if (name_phase == PH_AFTER_ZERO && ch == CharX) begin
			name_phase = PH_HEX;
			name_acc   = '0;
			hex_sat    = 1'b0;
			hex_done   = 1'b0;
			return 1'b0;
		end

		// first byte mixes with the seed, later ones with the running value
		mix_in   = (name_phase == PH_START) ? HashSeed : name_acc;
		name_acc = (mix_in ^ folded) * HashMult;
		if (ch == CharNul) begin
			hash = name_acc;
			hex  = 1'b0;
			restart_name();
			return 1'b1;
		end
		name_phase = (name_phase == PH_START && ch == CharZero) ? PH_AFTER_ZERO : PH_HASH;
		return 1'b0;
	endfunction

	function automatic void push_char(input logic [7:0] ch);
		char_item_t item;
		item.ch    = ch;
		item.typed = 1'b0;
		item.hash  = '0;
		item.hex   = 1'b0;
		name_bytes.push_back(item);
	endfunction

	function automatic logic [7:0] random_hex_digit();
		int n;
		n = $urandom_range(21);
		if (n < 10) return CharZero + 8'(n);
		if (n < 16) return CharLoA + 8'(n - 10);
		return CharUpA + 8'(n - 16);
	endfunction

	// any byte that ends a hex run: letters past f, top-bit bytes
	function automatic logic [7:0] random_non_hex();
		if ($urandom_range(1) == 0) return 8'($urandom_range(8'h67, 8'h7A));
		return 8'($urandom_range(8'h80, 8'hFF));
	endfunction

	// Random names, mostly well-formed hex or plain text with random content.
	function automatic void build_random_names(input int target);
		int         total;
		int         roll;
		int         n;
		name_kind_t kind;
		logic [7:0] pick;
		total = 0;
		while (total < target) begin
			total += name_bytes.size();
			roll = $urandom_range(99);
			if (roll < 35)      kind = KIND_HEX;
			else if (roll < 70) kind = KIND_PLAIN;
			else if (roll < 80) kind = KIND_ZERO_LEAD;
			else if (roll < 90) kind = KIND_BAD_PREFIX;
			else                kind = KIND_LONG_HEX;
			n = name_bytes.size();
			case (kind)
				KIND_HEX: begin
					push_char(CharZero);
					push_char(CharX);
					repeat ($urandom_range(2)) push_char(CharZero);
					repeat ($urandom_range(8)) push_char(random_hex_digit());
					if ($urandom_range(9) < 3) begin
						push_char(random_non_hex());
						repeat ($urandom_range(3)) push_char(8'($urandom_range(1, 255)));
					end
				end
				KIND_PLAIN: begin
					repeat ($urandom_range(12)) begin
						case ($urandom_range(3))
							0: pick = CharUpA + 8'($urandom_range(25));
							1: pick = CharLoA + 8'($urandom_range(25));
							default: pick = 8'($urandom_range(1, 255));
						endcase
						push_char(pick);
					end
				end
				KIND_ZERO_LEAD: begin
					// "0" alone, "0X", "00x", or '0' then anything
					push_char(CharZero);
					case ($urandom_range(3))
						0: ;
						1: push_char(8'h58);
						2: begin
							push_char(CharZero);
							push_char(CharX);
						end
						default: push_char(8'($urandom_range(1, 255)));
					endcase
					repeat ($urandom_range(4)) push_char(8'($urandom_range(1, 255)));
				end
				KIND_BAD_PREFIX: begin
					// whitespace, sign or a second prefix straight after "0x"
					push_char(CharZero);
					push_char(CharX);
					case ($urandom_range(4))
						0: push_char(8'h20);
						1: push_char(8'h09);
						2: push_char(8'h2B);
						3: push_char(8'h2D);
						default: begin
							push_char(CharZero);
							push_char(CharX);
						end
					endcase
					repeat ($urandom_range(3)) push_char(random_hex_digit());
				end
				default: begin
					// eight digits reach the top; more saturate
					push_char(CharZero);
					push_char(CharX);
					if ($urandom_range(3) == 0) begin
						repeat ($urandom_range(8, 10)) push_char($urandom_range(1) ? CharUpF : CharLoF);
					end else begin
						push_char(CharZero + 8'($urandom_range(1, 9)));
						repeat ($urandom_range(7, 11)) push_char(random_hex_digit());
					end
				end
			endcase
			push_char(CharNul);
			total += name_bytes.size() - n - n;
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < REPORT_LIMIT) begin
			$display("mismatch at %0t: %s got %08h want %08h", $realtime, what, got, want);
		end
		mismatch_count++;
	endtask

	// Offer every queued byte; bursts with random gaps unless steady.
	// Called at a falling edge and returns at one with the last item accepted.
	task automatic send_names(input bit steady);
		char_item_t   item;
		name_result_t res;
		logic [31:0]  hash;
		logic         hex;
		int           gap;
		while (name_bytes.size() != 0) begin
			item = name_bytes.pop_front();
			if (!steady && burst_left == 0) begin
				gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				burst_left = $urandom_range(1, 24);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= item.ch;
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			if (hash_byte(item.ch, hash, hex)) begin
				if (item.typed) begin
					res.hash = item.hash;
					res.hex  = item.hex;
				end else begin
					res.hash = hash;
					res.hex  = hex;
				end
				awaited_q.push_back(res);
			end
			if (burst_left != 0) burst_left--;
			@(negedge clk);
		end
	endtask

	// Result sink: the stall pattern is redrawn after each span, including
	// spells of no stall at all; one long hold-off on request.
	initial begin : sink
		int stall_pct;
		int span;
		m_tready  = 1'b0;
		stall_pct = 0;
		span      = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (span == 0) begin
				span = $urandom_range(20, 80);
				case ($urandom_range(3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end
			span--;
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Scoreboard: every accepted result against the oldest one owed.
	always @(posedge clk) begin : check_results
		name_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_q.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, '0);
			end else begin
				want = awaited_q.pop_front();
				if (m_tdata !== want.hash) report_mismatch("hash_value", m_tdata, want.hash);
				if (m_tuser !== want.hex) report_mismatch("was_hex", 32'(m_tuser), 32'(want.hex));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		char_item_t item;
		int         r;
		int         i;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		restart_name();

		// Directed names. Text is written last byte first; typed answers only
		// where they are obvious, the rest go through the predictor.
		directed_rows[0] = '{48'(CharNul), 4'd1, 1'b1, HashSeed * HashMult, 1'b0}; // empty
		directed_rows[1] = '{48'({CharNul, CharX, CharZero}), 4'd3, 1'b1, 32'h0, 1'b1};
		directed_rows[2] = '{48'({CharNul, CharZero}), 4'd2, 1'b0, 32'h0, 1'b0}; // "0" hashed
		// folding and sign extension, widest byte
		directed_rows[3] = '{48'({CharNul, 8'hFF, 8'h80, CharUpZ, CharUpA}), 4'd5, 1'b0,
			32'h0, 1'b0};
		// second prefix: '0' taken, stops at the 'x'
		directed_rows[4] = '{{CharNul, 8'h37, CharX, CharZero, CharX, CharZero}, 4'd6, 1'b1,
			32'h0, 1'b1};
		// whitespace after the prefix stops the parse
		directed_rows[5] = '{48'({CharNul, 8'h35, 8'h20, CharX, CharZero}), 4'd5, 1'b1,
			32'h0, 1'b1};
		// trailing bytes after a non-hex byte are ignored
		directed_rows[6] = '{{CharNul, 8'h31, 8'h67, CharUpF, CharX, CharZero}, 4'd6, 1'b1,
			32'hF, 1'b1};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (r = 0; r < DIRECTED_ROWS; r++) begin
			for (i = 0; i < directed_rows[r].len; i++) begin
				item.ch    = directed_rows[r].text[8 * i +: 8];
				item.typed = directed_rows[r].typed && (i == directed_rows[r].len - 1);
				item.hash  = directed_rows[r].hash;
				item.hex   = directed_rows[r].hex;
				name_bytes.push_back(item);
			end
		end
		send_names(1'b0);

		// sender pauses until the block has handed back everything
		s_tvalid <= 1'b0;
		do @(negedge clk); while (awaited_q.size() != 0);
		repeat (4) @(negedge clk);

		// sink holds off while empty names pour in, so the input must stall
		hold_req = 1'b1;
		repeat (12) push_char(CharNul);
		send_names(1'b1);

		build_random_names(RANDOM_ITEMS);
		send_names(1'b0);
		s_tvalid <= 1'b0;

		while (awaited_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
